[src/smxr_pkg.sv]
package smxr_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;

  localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;

  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;
  localparam int unsigned XO_ROT_A    = 55;
  localparam int unsigned XO_SHIFT    = 14;
  localparam int unsigned XO_ROT_B    = 36;

  localparam logic KIND_RESEED = 1'b0;
  localparam logic KIND_DRAW   = 1'b1;

  localparam logic METHOD_SPLITMIX = 1'b0;
  localparam logic METHOD_XORO     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XA,
    ST_MA_LL,
    ST_MA_HL,
    ST_MA_LH,
    ST_XB,
    ST_MB_LL,
    ST_MB_HL,
    ST_MB_LH,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD_SEED,
    DP_LOAD_DRAW,
    DP_XORO,
    DP_XOR_A,
    DP_XOR_B,
    DP_MUL_LL,
    DP_MUL_HL,
    DP_MUL_LH,
    DP_STORE_NEXT,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_b;
  } dp_cmd_t;

  typedef struct packed {
    logic last_word;
  } dp_status_t;

endpackage

[src/smxr_ctrl.sv]
module smxr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_kind,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_method,
  input  smxr_pkg::dp_status_t  status,
  output smxr_pkg::dp_cmd_t     cmd,
  output logic                  busy
);

  smxr_pkg::state_t state_r, state_nxt;
  logic             draw_r, draw_nxt;
  logic             method_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= smxr_pkg::ST_IDLE;
      draw_r   <= 1'b0;
      method_r <= smxr_pkg::METHOD_XORO;
    end else begin
      state_r <= state_nxt;
      draw_r  <= draw_nxt;
      if (cfg_wr_en) begin
        method_r <= cfg_method;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    draw_nxt  = draw_r;
    cmd.op    = smxr_pkg::DP_NONE;
    cmd.mul_b = 1'b0;
    busy      = 1'b1;
    case (state_r)
      smxr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_kind == smxr_pkg::KIND_DRAW) begin
            if (method_r == smxr_pkg::METHOD_XORO) begin
              cmd.op = smxr_pkg::DP_XORO;
            end else begin
              cmd.op    = smxr_pkg::DP_LOAD_DRAW;
              draw_nxt  = 1'b1;
              state_nxt = smxr_pkg::ST_XA;
            end
          end else begin
            cmd.op    = smxr_pkg::DP_LOAD_SEED;
            draw_nxt  = 1'b0;
            state_nxt = smxr_pkg::ST_XA;
          end
        end
      end
      smxr_pkg::ST_XA: begin
        cmd.op    = smxr_pkg::DP_XOR_A;
        state_nxt = smxr_pkg::ST_MA_LL;
      end
      smxr_pkg::ST_MA_LL: begin
        cmd.op    = smxr_pkg::DP_MUL_LL;
        state_nxt = smxr_pkg::ST_MA_HL;
      end
      smxr_pkg::ST_MA_HL: begin
        cmd.op    = smxr_pkg::DP_MUL_HL;
        state_nxt = smxr_pkg::ST_MA_LH;
      end
      smxr_pkg::ST_MA_LH: begin
        cmd.op    = smxr_pkg::DP_MUL_LH;
        state_nxt = smxr_pkg::ST_XB;
      end
      smxr_pkg::ST_XB: begin
        cmd.op    = smxr_pkg::DP_XOR_B;
        state_nxt = smxr_pkg::ST_MB_LL;
      end
      smxr_pkg::ST_MB_LL: begin
        cmd.op    = smxr_pkg::DP_MUL_LL;
        cmd.mul_b = 1'b1;
        state_nxt = smxr_pkg::ST_MB_HL;
      end
      smxr_pkg::ST_MB_HL: begin
        cmd.op    = smxr_pkg::DP_MUL_HL;
        cmd.mul_b = 1'b1;
        state_nxt = smxr_pkg::ST_MB_LH;
      end
      smxr_pkg::ST_MB_LH: begin
        cmd.op    = smxr_pkg::DP_MUL_LH;
        cmd.mul_b = 1'b1;
        state_nxt = smxr_pkg::ST_FIN;
      end
      smxr_pkg::ST_FIN: begin
        if (draw_r) begin
          cmd.op    = smxr_pkg::DP_EMIT;
          state_nxt = smxr_pkg::ST_IDLE;
        end else begin
          cmd.op = smxr_pkg::DP_STORE_NEXT;
          if (status.last_word) begin
            state_nxt = smxr_pkg::ST_IDLE;
          end else begin
            state_nxt = smxr_pkg::ST_XA;
          end
        end
      end
      default: begin
        state_nxt = smxr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/smxr_datapath.sv]
module smxr_datapath #(
  parameter int unsigned NUM_SEED_WORDS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smxr_pkg::dp_cmd_t             cmd,
  input  logic [smxr_pkg::WORD_W-1:0]   in_seed_value,
  output smxr_pkg::dp_status_t          status,
  output logic                          out_valid,
  output logic [smxr_pkg::WORD_W-1:0]   out_random_value
);

  localparam int unsigned IDX_W = $clog2(NUM_SEED_WORDS);
  localparam int unsigned W     = smxr_pkg::WORD_W;
  localparam int unsigned H     = smxr_pkg::HALF_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SEED_WORDS - 1);

  logic [W-1:0]     words_r [NUM_SEED_WORDS];
  logic [W-1:0]     words_nxt [NUM_SEED_WORDS];
  logic [W-1:0]     z_r, z_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [W-1:0]     out_value_r, out_value_nxt;

  logic [W-1:0] mul_const;
  logic [H-1:0] mul_x;
  logic [H-1:0] mul_y;
  logic [W-1:0] prod;
  logic [W-1:0] prod_up;
  logic [W-1:0] fin;
  logic [W-1:0] xo_t;
  logic [W-1:0] w_last_inc;

  assign mul_const = cmd.mul_b ? smxr_pkg::MIX_MUL_B : smxr_pkg::MIX_MUL_A;
  assign mul_x     = (cmd.op == smxr_pkg::DP_MUL_HL) ? z_r[W-1:H] : z_r[H-1:0];
  assign mul_y     = (cmd.op == smxr_pkg::DP_MUL_LH) ? mul_const[W-1:H] : mul_const[H-1:0];
  assign prod      = W'(mul_x) * W'(mul_y);
  assign prod_up   = {prod[H-1:0], {H{1'b0}}};
  assign fin       = z_r ^ (z_r >> smxr_pkg::MIX_SHIFT_C);
  assign xo_t      = words_r[0] ^ words_r[1];
  assign w_last_inc = words_r[NUM_SEED_WORDS-1] + smxr_pkg::GOLDEN_INC;

  assign status.last_word = (idx_r == LAST_IDX);
  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

  always_comb begin
    for (int i = 0; i < NUM_SEED_WORDS; i++) begin
      words_nxt[i] = words_r[i];
    end
    z_nxt         = z_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    case (cmd.op)
      smxr_pkg::DP_LOAD_SEED: begin
        z_nxt   = in_seed_value + smxr_pkg::GOLDEN_INC;
        idx_nxt = '0;
      end
      smxr_pkg::DP_LOAD_DRAW: begin
        words_nxt[NUM_SEED_WORDS-1] = w_last_inc;
        z_nxt                       = w_last_inc;
      end
      smxr_pkg::DP_XORO: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = words_r[0] + words_r[1];
        words_nxt[0]  = ((words_r[0] << smxr_pkg::XO_ROT_A)
                      | (words_r[0] >> (W - smxr_pkg::XO_ROT_A)))
                      ^ xo_t ^ (xo_t << smxr_pkg::XO_SHIFT);
        words_nxt[1]  = (xo_t << smxr_pkg::XO_ROT_B) | (xo_t >> (W - smxr_pkg::XO_ROT_B));
      end
      smxr_pkg::DP_XOR_A: begin
        z_nxt = z_r ^ (z_r >> smxr_pkg::MIX_SHIFT_A);
      end
      smxr_pkg::DP_XOR_B: begin
        z_nxt = z_r ^ (z_r >> smxr_pkg::MIX_SHIFT_B);
      end
      smxr_pkg::DP_MUL_LL: begin
        acc_nxt = prod;
      end
      smxr_pkg::DP_MUL_HL: begin
        acc_nxt = acc_r + prod_up;
      end
      smxr_pkg::DP_MUL_LH: begin
        z_nxt = acc_r + prod_up;
      end
      smxr_pkg::DP_STORE_NEXT: begin
        words_nxt[idx_r] = fin;
        idx_nxt          = idx_r + IDX_W'(1);
        z_nxt            = fin + smxr_pkg::GOLDEN_INC;
      end
      smxr_pkg::DP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = fin;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEED_WORDS; i++) begin
        words_r[i] <= '0;
      end
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_SEED_WORDS; i++) begin
        words_r[i] <= words_nxt[i];
      end
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r         <= z_nxt;
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule

[src/splitmix_xoroshiro_prng_top.sv]
// 64-bit random generator, SplitMix64 or xoroshiro128+ chosen by cfg_method
// (reset value 1, xoroshiro128+). A transaction is accepted when start is high
// and busy is low. Each draw gives one result, strobed by out_valid for exactly
// one cycle; the receiver cannot stall it, so capture it when out_valid is
// high. An xoroshiro128+ draw is strobed the cycle after acceptance and keeps
// busy low, so draws may follow every cycle. A SplitMix64 draw keeps busy high
// while it mixes the state; its result is strobed in the first cycle that busy
// is low again. A reseed gives no result and keeps busy high while mixing each
// seed word in turn. SplitMix64 uses one shared 32x32 multiplier that forms
// each 64-bit product in three passes. Write cfg_method only while idle.
module splitmix_xoroshiro_prng_top #(
  parameter int unsigned NUM_SEED_WORDS = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [smxr_pkg::WORD_W-1:0] in_seed_value,
  output logic                        out_valid,
  output logic [smxr_pkg::WORD_W-1:0] out_random_value,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_method
);

  smxr_pkg::dp_cmd_t    cmd;
  smxr_pkg::dp_status_t status;

  smxr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_kind    (in_kind),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_method (cfg_method),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  smxr_datapath #(
    .NUM_SEED_WORDS (NUM_SEED_WORDS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_seed_value    (in_seed_value),
    .status           (status),
    .out_valid        (out_valid),
    .out_random_value (out_random_value)
  );

endmodule
